FILE: design/assert_macros.svh
// Assertion macros shared by the gradient color table RTL.
// Each macro samples on posedge clk and is disabled while rst_n is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property holds at every clock edge.
`define GCT_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error(msg);

// Consequent holds in the cycle after the antecedent.
`define GCT_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: design/gct_pkg.sv
// Shared types and constants of the gradient color table.
// No dependencies; used by the interfaces, the cell, the divider and the top level.
`default_nettype none

package gct_pkg;

  localparam int MAX_STOPS_DEF = 8;
  localparam int TOTAL_W       = 6;
  localparam int POS_W         = 8;
  localparam int CH_W          = 8;
  localparam int CHANNELS      = 3;
  localparam int COLOR_W       = CH_W * CHANNELS;
  localparam int PROD_W        = 2 * CH_W;
  localparam int DIV_STEPS     = PROD_W;
  localparam int DCNT_W        = $clog2(DIV_STEPS + 1);

  typedef enum logic [1:0] {
    OP_ADD   = 2'd0,
    OP_QUERY = 2'd1,
    OP_CLEAR = 2'd2
  } opcode_t;

  // Data handed from one cell to the next one up the chain.
  typedef struct packed {
    logic [POS_W-1:0]   pos;
    logic [COLOR_W-1:0] color;
    logic               gt;   // occupied and position above the key
    logic               le;   // occupied and position at or below the key
  } gct_link_t;

  // Broadcast control from the top level to every cell.
  typedef struct packed {
    logic               add_en;
    logic               query_en;
    logic [POS_W-1:0]   key;
    logic [COLOR_W-1:0] color;
    logic [TOTAL_W-1:0] total;
  } gct_cell_ctl_t;

  // Segment end points presented by the selected cell.
  typedef struct packed {
    logic [POS_W-1:0]   cur_pos;
    logic [COLOR_W-1:0] cur_color;
    logic [POS_W-1:0]   prv_pos;
    logic [COLOR_W-1:0] prv_color;
  } gct_tap_t;

  // Virtual stop below cell 0: black at position 0.
  localparam gct_link_t LINK_HEAD = '{pos: '0, color: '0, gt: 1'b0, le: 1'b1};

endpackage

`default_nettype wire

FILE: design/gct_if.sv
// Request and result channel interfaces of the gradient color table.
// Depends on gct_pkg for field widths.
`default_nettype none

interface gct_in_if;
  logic                      valid;
  logic                      ready;
  logic [1:0]                opcode;
  logic [gct_pkg::POS_W-1:0] stop_position;
  logic [gct_pkg::CH_W-1:0]  stop_red;
  logic [gct_pkg::CH_W-1:0]  stop_green;
  logic [gct_pkg::CH_W-1:0]  stop_blue;
  logic [gct_pkg::POS_W-1:0] query_index;

  modport source (output valid, opcode, stop_position, stop_red, stop_green, stop_blue,
                  query_index, input ready);
  modport sink   (input valid, opcode, stop_position, stop_red, stop_green, stop_blue,
                  query_index, output ready);
endinterface

interface gct_out_if;
  logic                        valid;
  logic                        ready;
  logic [gct_pkg::CH_W-1:0]    color_red;
  logic [gct_pkg::CH_W-1:0]    color_green;
  logic [gct_pkg::CH_W-1:0]    color_blue;
  logic                        accepted;
  logic [gct_pkg::TOTAL_W-1:0] stops_held;

  modport source (output valid, color_red, color_green, color_blue, accepted, stops_held,
                  input ready);
  modport sink   (input valid, color_red, color_green, color_blue, accepted, stops_held,
                  output ready);
endinterface

`default_nettype wire

FILE: design/gct_cell.sv
// One stop slot of the sorted stop chain: holds a position and a color,
// shifts up for sorted insert and flags itself as segment end for a query.
// Depends on gct_pkg.
`default_nettype none

module gct_cell #(
  parameter int IDX = 0
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire gct_pkg::gct_cell_ctl_t ctl,
  input  wire gct_pkg::gct_link_t    link_in,
  output gct_pkg::gct_link_t         link_out,
  output gct_pkg::gct_tap_t          tap,
  output logic                       sel
);

  localparam logic [gct_pkg::TOTAL_W-1:0] IDX_W  = gct_pkg::TOTAL_W'(IDX);
  localparam logic [gct_pkg::TOTAL_W-1:0] IDX_P1 = gct_pkg::TOTAL_W'(IDX + 1);

  logic [gct_pkg::POS_W-1:0]   pos_r, pos_nxt;
  logic [gct_pkg::COLOR_W-1:0] color_r, color_nxt;
  logic                        sel_r, sel_nxt;
  logic                        occ, gt, is_last, is_free;

  assign occ     = ctl.total > IDX_W;
  assign gt      = occ && (pos_r > ctl.key);
  assign is_last = ctl.total == IDX_P1;
  assign is_free = ctl.total == IDX_W;

  always_comb begin
    pos_nxt   = pos_r;
    color_nxt = color_r;
    sel_nxt   = sel_r;
    if (ctl.add_en) begin
      // lower neighbor moving up takes precedence over the new stop
      if (link_in.gt) begin
        pos_nxt   = link_in.pos;
        color_nxt = link_in.color;
      end else if (gt || is_free) begin
        pos_nxt   = ctl.key;
        color_nxt = ctl.color;
      end
    end
    if (ctl.query_en) begin
      sel_nxt = occ && (is_last || gt) && link_in.le;
    end
  end

  always_ff @(posedge clk) begin
    pos_r   <= pos_nxt;
    color_r <= color_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sel_r <= 1'b0;
    end else begin
      sel_r <= sel_nxt;
    end
  end

  assign link_out = '{pos: pos_r, color: color_r, gt: gt, le: occ && !gt};
  assign tap      = sel_r ? gct_pkg::gct_tap_t'{cur_pos: pos_r, cur_color: color_r,
                                                prv_pos: link_in.pos,
                                                prv_color: link_in.color}
                          : '0;
  assign sel      = sel_r;

endmodule

`default_nettype wire

FILE: design/gct_divider.sv
// Restoring divider, one quotient bit per cycle, three lanes sharing a divisor.
// Depends on gct_pkg.
`default_nettype none

module gct_divider (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       start,
  input  wire logic [gct_pkg::PROD_W-1:0] dividend [gct_pkg::CHANNELS],
  input  wire logic [gct_pkg::CH_W-1:0]   divisor,
  output logic                            done,
  output logic [gct_pkg::PROD_W-1:0]      quotient [gct_pkg::CHANNELS]
);

  logic [gct_pkg::CH_W-1:0]   rem_r [gct_pkg::CHANNELS];
  logic [gct_pkg::CH_W-1:0]   rem_nxt [gct_pkg::CHANNELS];
  logic [gct_pkg::PROD_W-1:0] quo_r [gct_pkg::CHANNELS];
  logic [gct_pkg::PROD_W-1:0] quo_nxt [gct_pkg::CHANNELS];
  logic [gct_pkg::CH_W-1:0]   div_r, div_nxt;
  logic [gct_pkg::DCNT_W-1:0] cnt_r, cnt_nxt;
  logic                       busy_r, busy_nxt;
  logic                       done_r, done_nxt;
  logic [gct_pkg::CH_W:0]     trial [gct_pkg::CHANNELS];

  always_comb begin
    div_nxt  = div_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    for (int l = 0; l < gct_pkg::CHANNELS; l++) begin
      trial[l]   = {rem_r[l], quo_r[l][gct_pkg::PROD_W-1]};
      rem_nxt[l] = rem_r[l];
      quo_nxt[l] = quo_r[l];
    end
    if (start) begin
      div_nxt  = divisor;
      cnt_nxt  = gct_pkg::DCNT_W'(gct_pkg::DIV_STEPS);
      busy_nxt = 1'b1;
      for (int l = 0; l < gct_pkg::CHANNELS; l++) begin
        rem_nxt[l] = '0;
        quo_nxt[l] = dividend[l];
      end
    end else if (busy_r) begin
      for (int l = 0; l < gct_pkg::CHANNELS; l++) begin
        if (trial[l] >= {1'b0, div_r}) begin
          rem_nxt[l] = gct_pkg::CH_W'(trial[l] - {1'b0, div_r});
          quo_nxt[l] = {quo_r[l][gct_pkg::PROD_W-2:0], 1'b1};
        end else begin
          rem_nxt[l] = trial[l][gct_pkg::CH_W-1:0];
          quo_nxt[l] = {quo_r[l][gct_pkg::PROD_W-2:0], 1'b0};
        end
      end
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == gct_pkg::DCNT_W'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    div_r <= div_nxt;
    rem_r <= rem_nxt;
    quo_r <= quo_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      cnt_r  <= cnt_nxt;
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
  end

  assign done     = done_r;
  assign quotient = quo_r;

endmodule

`default_nettype wire

FILE: design/gradient_color_table_core.sv
// Gradient color table: sorted list of color stops with a linear-ramp lookup.
//
// Channels: in_req carries one request per valid/ready handshake with an opcode
// (add stop, query index, clear). out_rsp returns exactly one result per request:
// the color (zero unless query), an accepted flag and the stop count afterwards.
// Stops live in a chain of MAX_STOPS cells; an add shifts all the upper cells up
// together, so the chain stays sorted.
// Flow: add, clear and the unused opcode go from S_IDLE straight to S_DONE. A query
// passes S_IDLE, S_PICK, S_DONE when the list is empty or the index is at or
// past its segment end, otherwise S_IDLE, S_PICK, S_LOAD, S_DIV, S_DONE, while the
// 16-step serial divider forms (cur - prev) * k / span for the three channels at once.
// One request is in work at a time, so the next request is taken only once the last
// result has left S_DONE for the output register; in_req.ready is high while the
// core is idle, including while a finished result waits in the output register.
// Reset (rst_n low, synchronous) empties the stop list and drops any pending
// result; the stop storage itself is not cleared and needs no sweep.
// If out_rsp.ready stays low, the result is held and the core stalls with the
// next result until the output register frees up.
`default_nettype none
`include "assert_macros.svh"

module gradient_color_table_core #(
  parameter int MAX_STOPS = gct_pkg::MAX_STOPS_DEF
) (
  input  wire logic  clk,
  input  wire logic  rst_n,
  gct_in_if.sink     in_req,
  gct_out_if.source  out_rsp
);

  localparam int CH = gct_pkg::CH_W;
  localparam logic [gct_pkg::TOTAL_W-1:0] MAX_W = gct_pkg::TOTAL_W'(MAX_STOPS);

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_PICK = 5'b00010,
    S_LOAD = 5'b00100,
    S_DIV  = 5'b01000,
    S_DONE = 5'b10000
  } state_t;

  state_t                          state_r, state_nxt;
  logic [gct_pkg::TOTAL_W-1:0]     total_r, total_nxt;
  logic [gct_pkg::POS_W-1:0]       q_r, q_nxt;
  logic [gct_pkg::COLOR_W-1:0]     res_rgb_r, res_rgb_nxt;
  logic                            res_ok_r, res_ok_nxt;
  logic [gct_pkg::POS_W-1:0]       span_r, span_nxt;
  logic [gct_pkg::POS_W-1:0]       k_r, k_nxt;
  logic [CH-1:0]                   mag_r [gct_pkg::CHANNELS];
  logic [CH-1:0]                   mag_nxt [gct_pkg::CHANNELS];
  logic [CH-1:0]                   from_r [gct_pkg::CHANNELS];
  logic [CH-1:0]                   from_nxt [gct_pkg::CHANNELS];
  logic [gct_pkg::CHANNELS-1:0]    neg_r, neg_nxt;
  logic                            out_valid_r, out_valid_nxt;
  logic [gct_pkg::COLOR_W-1:0]     out_rgb_r, out_rgb_nxt;
  logic                            out_ok_r, out_ok_nxt;
  logic [gct_pkg::TOTAL_W-1:0]     out_held_r, out_held_nxt;

  logic                            acc, div_start, div_done, out_load;
  logic [CH-1:0]                   cur_ch, prv_ch;
  logic [gct_pkg::PROD_W-1:0]      dividend [gct_pkg::CHANNELS];
  logic [gct_pkg::PROD_W-1:0]      quotient [gct_pkg::CHANNELS];
  gct_pkg::gct_cell_ctl_t          ctl;
  gct_pkg::gct_link_t              link_in_w  [MAX_STOPS];
  gct_pkg::gct_link_t              link_out_w [MAX_STOPS];
  gct_pkg::gct_tap_t               tap_w [MAX_STOPS];
  gct_pkg::gct_tap_t               tap_or;
  logic [MAX_STOPS-1:0]            sel_vec;

  assign in_req.ready = (state_r == S_IDLE);
  assign acc          = in_req.valid && in_req.ready;

  assign ctl.add_en   = acc && (in_req.opcode == gct_pkg::OP_ADD) && (total_r < MAX_W);
  assign ctl.query_en = acc && (in_req.opcode == gct_pkg::OP_QUERY);
  assign ctl.key      = (in_req.opcode == gct_pkg::OP_ADD) ? in_req.stop_position
                                                           : in_req.query_index;
  assign ctl.color    = {in_req.stop_red, in_req.stop_green, in_req.stop_blue};
  assign ctl.total    = total_r;

  for (genvar i = 0; i < MAX_STOPS; i++) begin : g_cell
    if (i == 0) begin : g_head
      assign link_in_w[i] = gct_pkg::LINK_HEAD;
    end else begin : g_body
      assign link_in_w[i] = link_out_w[i-1];
    end
    gct_cell #(.IDX(i)) u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .ctl      (ctl),
      .link_in  (link_in_w[i]),
      .link_out (link_out_w[i]),
      .tap      (tap_w[i]),
      .sel      (sel_vec[i])
    );
  end

  // at most one cell is selected, so an OR collects its segment
  always_comb begin
    tap_or = '0;
    for (int i = 0; i < MAX_STOPS; i++) begin
      tap_or = tap_or | tap_w[i];
    end
  end

  for (genvar l = 0; l < gct_pkg::CHANNELS; l++) begin : g_prod
    assign dividend[l] = {{CH{1'b0}}, mag_r[l]} * {{CH{1'b0}}, k_r};
  end

  assign div_start = (state_r == S_LOAD);

  gct_divider u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (dividend),
    .divisor  (span_r),
    .done     (div_done),
    .quotient (quotient)
  );

  assign out_load = (state_r == S_DONE) && (!out_valid_r || out_rsp.ready);

  always_comb begin
    state_nxt   = state_r;
    total_nxt   = total_r;
    q_nxt       = q_r;
    res_rgb_nxt = res_rgb_r;
    res_ok_nxt  = res_ok_r;
    span_nxt    = span_r;
    k_nxt       = k_r;
    mag_nxt     = mag_r;
    from_nxt    = from_r;
    neg_nxt     = neg_r;
    cur_ch      = '0;
    prv_ch      = '0;
    unique case (state_r)
      S_IDLE: begin
        if (acc) begin
          res_rgb_nxt = '0;
          state_nxt   = S_DONE;
          unique case (in_req.opcode)
            gct_pkg::OP_ADD: begin
              res_ok_nxt = ctl.add_en;
              if (ctl.add_en) begin
                total_nxt = total_r + 1'b1;
              end
            end
            gct_pkg::OP_QUERY: begin
              q_nxt     = in_req.query_index;
              state_nxt = S_PICK;
            end
            gct_pkg::OP_CLEAR: begin
              total_nxt  = '0;
              res_ok_nxt = 1'b1;
            end
            default: begin
              res_ok_nxt = 1'b0;
            end
          endcase
        end
      end
      S_PICK: begin
        res_ok_nxt = 1'b1;
        if (total_r == '0) begin
          res_rgb_nxt = '0;
          state_nxt   = S_DONE;
        end else if (q_r >= tap_or.cur_pos) begin
          res_rgb_nxt = tap_or.cur_color;
          state_nxt   = S_DONE;
        end else begin
          span_nxt = tap_or.cur_pos - tap_or.prv_pos;
          k_nxt    = q_r - tap_or.prv_pos;
          for (int l = 0; l < gct_pkg::CHANNELS; l++) begin
            cur_ch      = tap_or.cur_color[gct_pkg::COLOR_W-1-CH*l -: CH];
            prv_ch      = tap_or.prv_color[gct_pkg::COLOR_W-1-CH*l -: CH];
            from_nxt[l] = prv_ch;
            neg_nxt[l]  = cur_ch < prv_ch;
            mag_nxt[l]  = (cur_ch < prv_ch) ? (prv_ch - cur_ch) : (cur_ch - prv_ch);
          end
          state_nxt = S_LOAD;
        end
      end
      S_LOAD: begin
        state_nxt = S_DIV;
      end
      S_DIV: begin
        if (div_done) begin
          // quotient magnitude is below 256; sign applied after truncation
          for (int l = 0; l < gct_pkg::CHANNELS; l++) begin
            res_rgb_nxt[gct_pkg::COLOR_W-1-CH*l -: CH] =
              neg_r[l] ? (from_r[l] - quotient[l][CH-1:0])
                       : (from_r[l] + quotient[l][CH-1:0]);
          end
          state_nxt = S_DONE;
        end
      end
      S_DONE: begin
        if (out_load) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r && !out_rsp.ready;
    out_rgb_nxt   = out_rgb_r;
    out_ok_nxt    = out_ok_r;
    out_held_nxt  = out_held_r;
    if (out_load) begin
      out_valid_nxt = 1'b1;
      out_rgb_nxt   = res_rgb_r;
      out_ok_nxt    = res_ok_r;
      out_held_nxt  = total_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      total_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      total_r     <= total_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    q_r        <= q_nxt;
    res_rgb_r  <= res_rgb_nxt;
    res_ok_r   <= res_ok_nxt;
    span_r     <= span_nxt;
    k_r        <= k_nxt;
    mag_r      <= mag_nxt;
    from_r     <= from_nxt;
    neg_r      <= neg_nxt;
    out_rgb_r  <= out_rgb_nxt;
    out_ok_r   <= out_ok_nxt;
    out_held_r <= out_held_nxt;
  end

  assign out_rsp.valid       = out_valid_r;
  assign out_rsp.color_red   = out_rgb_r[gct_pkg::COLOR_W-1 -: CH];
  assign out_rsp.color_green = out_rgb_r[gct_pkg::COLOR_W-1-CH -: CH];
  assign out_rsp.color_blue  = out_rgb_r[CH-1:0];
  assign out_rsp.accepted    = out_ok_r;
  assign out_rsp.stops_held  = out_held_r;

  `GCT_ASSERT(a_total_cap, total_r <= MAX_W, "stop count above capacity")
  `GCT_ASSERT(a_one_segment, (state_r == S_PICK && total_r != '0) |-> $onehot(sel_vec),
              "query selected no segment or several")
  `GCT_ASSERT(a_div_done_state, div_done |-> (state_r == S_DIV), "divider finished outside divide state")
  `GCT_ASSERT_NEXT(a_result_loaded, out_load, out_valid_r && state_r == S_IDLE,
                   "result not presented after load")

endmodule

`default_nettype wire
